// File: sv/fqrv_pkg.sv
// ----------------------------------------------------------------------------
// fqrv_pkg
// Shared types and constants for the FIFO queue with remove-by-value.
// ----------------------------------------------------------------------------
package fqrv_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_W       = 5;

   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_REMOVE  = 2'd2,
      CMD_PEEK    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // Broadcast from the top level to every cell
   typedef struct packed {
      logic                       accept;
      cmd_type                    cmd;
      logic signed [VALUE_W-1:0]  value;
   } cell_ctl_type;

endpackage

// File: sv/fifo_queue_with_remove_by_value.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_value
// Bounded FIFO of signed values with enqueue, dequeue, peek and removal of
// the oldest entry equal to a given value, built as a row of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries one command and a value.
//   Response channel (rsp_valid / rsp_stall) returns one transaction per
//   command: the value read (zero unless dequeue or peek succeeds), a status
//   and the occupancy after the command.
//   Every cell compares its entry with the request value; in the same cycle,
//   cells shift toward the front on dequeue, and on remove from the oldest
//   match (found by a flag rippling front to back along the row) rearwards.
//   The single response register makes the response valid in the cycle after
//   acceptance and takes one command per cycle while req_stall is low.
//   While the receiver stalls and the response register is full, req_stall
//   is high and the queue holds.
//   Reset empties the queue and drops any pending response.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_by_value (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [1:0]                              req_command,
   input  logic signed [fqrv_pkg::VALUE_W-1:0]     req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [fqrv_pkg::VALUE_W-1:0]     rsp_result_value,
   output logic [1:0]                              rsp_status,
   output logic [fqrv_pkg::OCC_W-1:0]              rsp_occupancy
);

   localparam int D = fqrv_pkg::QUEUE_DEPTH;

   fqrv_pkg::cell_ctl_type                ctl;
   logic                                  accept;
   logic [D:0]                            cell_vld;
   logic signed [fqrv_pkg::VALUE_W-1:0]   cell_dat [D:0];
   logic [D:0]                            found_chain;
   logic                                  empty;
   logic                                  full;

   logic [fqrv_pkg::COUNT_W-1:0]          count_ff;
   logic [fqrv_pkg::COUNT_W-1:0]          count_in;
   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   logic signed [fqrv_pkg::VALUE_W-1:0]   res_ff;
   logic signed [fqrv_pkg::VALUE_W-1:0]   res_in;
   fqrv_pkg::status_type                  status_ff;
   fqrv_pkg::status_type                  status_in;
   logic [fqrv_pkg::OCC_W-1:0]            occ_ff;
   logic [fqrv_pkg::OCC_W-1:0]            occ_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign ctl.accept = accept;
   assign ctl.cmd    = fqrv_pkg::cmd_type'(req_command);
   assign ctl.value  = req_value;

   // Beyond the last cell: empty, zero
   assign cell_vld[D]    = 1'b0;
   assign cell_dat[D]    = '0;
   assign found_chain[0] = 1'b0;

   for (genvar i = 0; i < D; i++) begin : g_cell
      logic prev_vld;
      if (i == 0) begin : g_head
         assign prev_vld = 1'b1;
      end else begin : g_body
         assign prev_vld = cell_vld[i-1];
      end

      fqrv_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_valid (prev_vld),
         .prev_found (found_chain[i]),
         .next_valid (cell_vld[i+1]),
         .next_data  (cell_dat[i+1]),
         .valid      (cell_vld[i]),
         .data       (cell_dat[i]),
         .found      (found_chain[i+1])
      );
   end

   assign empty = !cell_vld[0];
   assign full  = cell_vld[D-1];

   always_comb begin
      res_in    = '0;
      status_in = fqrv_pkg::ST_OK;
      count_in  = count_ff;
      case (ctl.cmd)
         fqrv_pkg::CMD_ENQUEUE: begin
            if (full) begin
               status_in = fqrv_pkg::ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         fqrv_pkg::CMD_DEQUEUE: begin
            if (empty) begin
               status_in = fqrv_pkg::ST_EMPTY;
            end else begin
               res_in   = cell_dat[0];
               count_in = count_ff - 1'b1;
            end
         end
         fqrv_pkg::CMD_REMOVE: begin
            if (empty) begin
               status_in = fqrv_pkg::ST_EMPTY;
            end else if (!found_chain[D]) begin
               status_in = fqrv_pkg::ST_NOTFOUND;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            if (empty) begin
               status_in = fqrv_pkg::ST_EMPTY;
            end else begin
               res_in = cell_dat[0];
            end
         end
      endcase
      occ_in = fqrv_pkg::OCC_W'(count_in);
   end

   // Response register: load on accept, clear once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff    <= res_in;
         status_ff <= status_in;
         occ_ff    <= occ_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = res_ff;
   assign rsp_status       = status_ff;
   assign rsp_occupancy    = occ_ff;

endmodule

// File: sv/fqrv_cell.sv
// ----------------------------------------------------------------------------
// fqrv_cell
// One queue entry: holds a value and a valid flag, loads on enqueue, takes
// its rear neighbour's contents when the entries behind a gap close up.
// ----------------------------------------------------------------------------
module fqrv_cell (
   input  logic                                    clock,
   input  logic                                    reset,
   input  fqrv_pkg::cell_ctl_type                  ctl,
   input  logic                                    prev_valid,
   input  logic                                    prev_found,
   input  logic                                    next_valid,
   input  logic signed [fqrv_pkg::VALUE_W-1:0]     next_data,
   output logic                                    valid,
   output logic signed [fqrv_pkg::VALUE_W-1:0]     data,
   output logic                                    found
);

   logic                                  valid_ff;
   logic                                  valid_in;
   logic signed [fqrv_pkg::VALUE_W-1:0]   data_ff;
   logic signed [fqrv_pkg::VALUE_W-1:0]   data_in;
   logic                                  match;
   logic                                  shift;
   logic                                  load;

   assign match = valid_ff && (data_ff == ctl.value);
   assign found = prev_found || match;

   // Shift on dequeue, and on remove from the oldest match rearwards
   assign shift = ctl.accept &&
                  ((ctl.cmd == fqrv_pkg::CMD_DEQUEUE) ||
                   ((ctl.cmd == fqrv_pkg::CMD_REMOVE) && found));
   // First free cell takes the enqueued value
   assign load  = ctl.accept && (ctl.cmd == fqrv_pkg::CMD_ENQUEUE) &&
                  !valid_ff && prev_valid;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (shift) begin
         valid_in = next_valid;
         data_in  = next_data;
      end else if (load) begin
         valid_in = 1'b1;
         data_in  = ctl.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule
